// ----- rtl/fts_pkg.sv -----
// Shared types and constants for the frequency table target selection block.
// No dependencies; every other file imports this package.
package fts_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned FREQ_W      = 32;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned POS_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [FREQ_W-1:0] FREQ_ALL_ONES = '1;
  localparam logic [FREQ_W-1:0] FREQ_ZERO     = '0;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ = 1'b1;

  localparam logic REL_LOW_AT_OR_ABOVE  = 1'b0;
  localparam logic REL_HIGH_AT_OR_BELOW = 1'b1;

  localparam logic ST_SELECTED = 1'b0;
  localparam logic ST_NO_MATCH = 1'b1;

  typedef struct packed {
    logic [FREQ_W-1:0] entry_freq;
    logic              entry_valid;
    logic [FREQ_W-1:0] goal_freq;
    logic              relation;
    logic              last_entry;
  } fts_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] chosen_index;
    logic               status;
  } fts_out_t;

  typedef struct packed {
    logic [FREQ_W-1:0] low_freq;
    logic [FREQ_W-1:0] high_freq;
  } window_t;

endpackage

// ----- rtl/freq_table_target_select.sv -----
// Frequency table target selection: one table entry is taken per request, one
// per cycle, and the final entry of a search gives one result, which passes
// through the single input register and then the result register before it
// leaves. Entries stall only while a finished result waits and a new last
// entry reaches the trackers. Write the window registers only while idle.
// Depends on fts_pkg, fts_cfg_regs, fts_tracker and fts_out_reg.
module freq_table_target_select
  import fts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fts_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fts_out_t             out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data
);

  window_t  window;
  logic     res_valid;
  logic     res_ready;
  fts_out_t res;

  fts_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .window    (window)
  );

  fts_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .window    (window),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  fts_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ----- rtl/fts_cfg_regs.sv -----
// Policy window registers written through the plain configuration port.
// Depends on fts_pkg.
module fts_cfg_regs
  import fts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_data,
  output window_t              window
);

  always_ff @(posedge clk) begin
    if (rst) begin
      window.low_freq  <= FREQ_ZERO;
      window.high_freq <= FREQ_ALL_ONES;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MIN_FREQ: window.low_freq <= cfg_data;
        REG_MAX_FREQ: window.high_freq <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/fts_tracker.sv -----
// Input register plus optimal and fallback trackers; one entry per cycle unless stalled.
// Depends on fts_pkg.
module fts_tracker
  import fts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  window_t  window,
  input  logic     in_valid,
  input  fts_in_t  in_data,
  output logic     in_stall,
  input  logic     res_ready,
  output logic     res_valid,
  output fts_out_t res
);

  logic               s1_valid;
  fts_in_t            s1_item;

  logic [FREQ_W-1:0]  best_freq;
  logic [INDEX_W-1:0] best_index;
  logic               best_found;
  logic [FREQ_W-1:0]  fallback_freq;
  logic [INDEX_W-1:0] fallback_index;
  logic               fallback_found;
  logic [POS_W-1:0]   entry_position;

  logic [FREQ_W-1:0]  best_freq_next;
  logic [INDEX_W-1:0] best_index_next;
  logic               best_found_next;
  logic [FREQ_W-1:0]  fallback_freq_next;
  logic [INDEX_W-1:0] fallback_index_next;
  logic               fallback_found_next;

  logic               first;
  logic               high_rel;
  logic               usable;
  logic               below_target;
  logic               above_target;
  logic               beats_best;
  logic               beats_fallback;
  logic               advance;
  logic [INDEX_W-1:0] pos_index;

  assign in_stall = s1_valid && s1_item.last_entry && !res_ready;
  assign advance  = s1_valid && !in_stall;

  assign first     = (entry_position == '0);
  assign high_rel  = (s1_item.relation == REL_HIGH_AT_OR_BELOW);
  assign pos_index = INDEX_W'(entry_position);

  assign usable = (entry_position < POS_W'(TABLE_DEPTH)) && s1_item.entry_valid &&
                  (s1_item.entry_freq >= window.low_freq) &&
                  (s1_item.entry_freq <= window.high_freq);
  assign below_target = (s1_item.entry_freq <= s1_item.goal_freq);
  assign above_target = (s1_item.entry_freq >= s1_item.goal_freq);

  always_comb begin
    logic base_high;
    base_high           = first ? high_rel : 1'b0;
    best_freq_next      = best_freq;
    best_index_next     = best_index;
    best_found_next     = best_found;
    fallback_freq_next  = fallback_freq;
    fallback_index_next = fallback_index;
    fallback_found_next = fallback_found;
    if (first) begin
      best_freq_next      = base_high ? FREQ_ZERO : FREQ_ALL_ONES;
      fallback_freq_next  = base_high ? FREQ_ALL_ONES : FREQ_ZERO;
      best_index_next     = '0;
      best_found_next     = 1'b0;
      fallback_index_next = '0;
      fallback_found_next = 1'b0;
    end
    beats_best     = high_rel ? (s1_item.entry_freq >= best_freq_next)
                              : (s1_item.entry_freq <= best_freq_next);
    beats_fallback = high_rel ? (s1_item.entry_freq <= fallback_freq_next)
                              : (s1_item.entry_freq >= fallback_freq_next);
    if (usable) begin
      if (high_rel ? below_target : above_target) begin
        if (beats_best) begin
          best_freq_next  = s1_item.entry_freq;
          best_index_next = pos_index;
          best_found_next = 1'b1;
        end
      end else if (beats_fallback) begin
        fallback_freq_next  = s1_item.entry_freq;
        fallback_index_next = pos_index;
        fallback_found_next = 1'b1;
      end
    end
  end

  always_comb begin
    res_valid = advance && s1_item.last_entry;
    if (best_found_next) begin
      res.chosen_index = best_index_next;
      res.status       = ST_SELECTED;
    end else if (fallback_found_next) begin
      res.chosen_index = fallback_index_next;
      res.status       = ST_SELECTED;
    end else begin
      res.chosen_index = '0;
      res.status       = ST_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_freq      <= FREQ_ZERO;
      best_index     <= '0;
      best_found     <= 1'b0;
      fallback_freq  <= FREQ_ZERO;
      fallback_index <= '0;
      fallback_found <= 1'b0;
      entry_position <= '0;
    end else if (advance) begin
      if (s1_item.last_entry) begin
        best_freq      <= FREQ_ZERO;
        best_index     <= '0;
        best_found     <= 1'b0;
        fallback_freq  <= FREQ_ZERO;
        fallback_index <= '0;
        fallback_found <= 1'b0;
        entry_position <= '0;
      end else begin
        best_freq      <= best_freq_next;
        best_index     <= best_index_next;
        best_found     <= best_found_next;
        fallback_freq  <= fallback_freq_next;
        fallback_index <= fallback_index_next;
        fallback_found <= fallback_found_next;
        // saturate at the table depth
        if (entry_position < POS_W'(TABLE_DEPTH)) begin
          entry_position <= entry_position + POS_W'(1);
        end
      end
    end
  end

endmodule

// ----- rtl/fts_out_reg.sv -----
// Result register between the tracker and the output channel.
// Depends on fts_pkg.
module fts_out_reg
  import fts_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     res_valid,
  input  fts_out_t res,
  output logic     res_ready,
  output logic     out_valid,
  output fts_out_t out_data,
  input  logic     out_stall
);

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule
